FILE: design/nrbps_pkg.sv
package nrbps_pkg;

    // Interleaver table G: element k of the message lands at word position PERM_G[k]
    localparam logic [4:0] PERM_G [32] = '{
        5'd16, 5'd23, 5'd18, 5'd17, 5'd8,  5'd30, 5'd10, 5'd6,
        5'd24, 5'd7,  5'd0,  5'd5,  5'd3,  5'd2,  5'd1,  5'd4,
        5'd9,  5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd19, 5'd20,
        5'd21, 5'd22, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd31
    };

    localparam int WORD_W    = 32;
    localparam int POS_W     = 5;
    localparam int SKIP_W    = 11;
    localparam int GOLD_W    = 31;
    localparam int CELL_ID_W = 10;
    localparam int MODE_W    = 2;
    localparam int CFG_DATA_W = 10;

    // Gold sequence start offset and per-v step for each block count
    localparam logic [SKIP_W-1:0] GOLD_NC  = 11'd1600;
    localparam logic [SKIP_W-1:0] STEP_64  = 11'd26;
    localparam logic [SKIP_W-1:0] STEP_OTH = 11'd29;

    // Configuration register indexes
    localparam logic CFG_CELL_ID    = 1'b0;
    localparam logic CFG_BLOCK_MODE = 1'b1;

    // Block count mode codes
    localparam logic [MODE_W-1:0] MODE_4BLK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_8BLK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_64BLK = 2'd2;

    // Item kinds
    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SKIP,
        ST_SCRAM,
        ST_DONE
    } t_seq_state;

    typedef struct packed {
        logic init;
        logic adv;
    } t_gold_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_sts;

endpackage

FILE: design/nrbps_gold.sv
module nrbps_gold (
    input  logic                                i_clk,
    input  nrbps_pkg::t_gold_ctl                i_ctl,
    input  logic [nrbps_pkg::CELL_ID_W-1:0]     i_seed,
    output logic                                o_bit
);
    import nrbps_pkg::*;

    logic [GOLD_W-1:0] r_x1;
    logic [GOLD_W-1:0] r_x2;
    logic [GOLD_W-1:0] n_x1;
    logic [GOLD_W-1:0] n_x2;
    logic              f1;
    logic              f2;

    always_comb begin
        f1 = r_x1[0] ^ r_x1[3];
        f2 = r_x2[0] ^ r_x2[1] ^ r_x2[2] ^ r_x2[3];
        n_x1 = r_x1;
        n_x2 = r_x2;
        if (i_ctl.init) begin
            n_x1 = GOLD_W'(1);
            n_x2 = GOLD_W'(i_seed);
        end else if (i_ctl.adv) begin
            n_x1 = {f1, r_x1[GOLD_W-1:1]};
            n_x2 = {f2, r_x2[GOLD_W-1:1]};
        end
    end

    // LFSR state is payload: always seeded before use
    always_ff @(posedge i_clk) begin
        r_x1 <= n_x1;
        r_x2 <= n_x2;
    end

    assign o_bit = r_x1[0] ^ r_x2[0];

endmodule

FILE: design/nrbps_seq.sv
module nrbps_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [nrbps_pkg::WORD_W-1:0]     i_word,
    input  logic                             i_is64,
    input  logic                             i_take,
    input  logic                             i_gold_bit,
    output nrbps_pkg::t_gold_ctl             o_gold,
    output nrbps_pkg::t_seq_sts              o_sts,
    output logic [nrbps_pkg::WORD_W-1:0]     o_word
);
    import nrbps_pkg::*;

    t_seq_state          r_state;
    t_seq_state          n_state;
    logic [SKIP_W-1:0]   r_cnt;
    logic [SKIP_W-1:0]   n_cnt;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    n_pos;
    logic [WORD_W-1:0]   r_word;
    logic [WORD_W-1:0]   n_word;
    logic [SKIP_W-1:0]   step;
    logic [SKIP_W-1:0]   offs;
    logic [1:0]          v;
    logic                exempt;
    logic                s_bit;

    // v from the two exempt frame-number positions
    assign v = {i_word[PERM_G[7]], i_word[PERM_G[8]]};
    assign step = i_is64 ? STEP_64 : STEP_OTH;

    always_comb begin
        case (v)
            2'd0:    offs = '0;
            2'd1:    offs = step;
            2'd2:    offs = step << 1;
            default: offs = step + (step << 1);
        endcase
    end

    always_comb begin
        exempt = (r_pos == PERM_G[10]) || (r_pos == PERM_G[7]) || (r_pos == PERM_G[8]);
        if (i_is64) begin
            exempt = exempt || (r_pos == PERM_G[11]) || (r_pos == PERM_G[12])
                     || (r_pos == PERM_G[13]);
        end
        s_bit = exempt ? 1'b0 : i_gold_bit;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_SKIP;
            ST_SKIP:  if (r_cnt == SKIP_W'(1)) n_state = ST_SCRAM;
            ST_SCRAM: if (r_pos == POS_W'(WORD_W - 1)) n_state = ST_DONE;
            ST_DONE:  if (i_take) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_gold = '0;
        o_sts  = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_gold.init = i_start;
                o_sts.idle  = 1'b1;
            end
            ST_SKIP:  o_gold.adv = 1'b1;
            ST_SCRAM: o_gold.adv = !exempt;
            ST_DONE:  o_sts.done = 1'b1;
            default: begin
                o_gold = '0;
            end
        endcase
    end

    // Datapath: word rotates once through position 0 during scrambling
    always_comb begin
        n_cnt  = r_cnt;
        n_pos  = r_pos;
        n_word = r_word;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cnt  = GOLD_NC + offs;
                    n_word = i_word;
                end
            end
            ST_SKIP: begin
                n_cnt = r_cnt - SKIP_W'(1);
                n_pos = '0;
            end
            ST_SCRAM: begin
                n_pos  = r_pos + POS_W'(1);
                n_word = {r_word[0] ^ s_bit, r_word[WORD_W-1:1]};
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_pos  <= n_pos;
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

FILE: design/nr_broadcast_payload_pack_scramble.sv
// Channel   Handshake                 Payload
// --------  ------------------------  ------------------------------------------------
// input     i_in_valid / o_in_ready   i_kind, i_payload_bits, i_sfn_low, i_half_frame,
//                                     i_block_index, i_offset_msb, i_coded_word
// output    o_out_valid / i_out_ready o_word_out, o_payload_out, o_sfn_out,
//                                     o_half_frame_out, o_block_index_out, o_offset_msb_out
// config    i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// A word runs through the states idle, skip, scramble and done: the Gold LFSR makes
// M*v + 1600 skip steps, then the word makes 32 scrambling steps.
// Synchronous active-low reset; afterwards cell_id is 0 and block_count_mode is 1.
// Input is taken only while the sequencer is idle. A finished word waits in the
// output register; the next word is accepted while it waits to be taken.
module nr_broadcast_payload_pack_scramble (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic                                 i_cfg_index,
    input  logic [nrbps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_kind,
    input  logic [23:0]                          i_payload_bits,
    input  logic [3:0]                           i_sfn_low,
    input  logic                                 i_half_frame,
    input  logic [5:0]                           i_block_index,
    input  logic                                 i_offset_msb,
    input  logic [31:0]                          i_coded_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [31:0]                          o_word_out,
    output logic [23:0]                          o_payload_out,
    output logic [3:0]                           o_sfn_out,
    output logic                                 o_half_frame_out,
    output logic [5:0]                           o_block_index_out,
    output logic                                 o_offset_msb_out
);
    import nrbps_pkg::*;

    // Configuration registers
    logic [CELL_ID_W-1:0] r_cell_id;
    logic [MODE_W-1:0]    r_mode;

    // Per-item context held while the sequencer runs
    logic                 r_kind;
    logic [5:0]           r_ssb;

    logic                 r_out_valid;
    logic [31:0]          r_word_out;
    logic [23:0]          r_payload_out;
    logic [3:0]           r_sfn_out;
    logic                 r_half_frame_out;
    logic [5:0]           r_block_index_out;
    logic                 r_offset_msb_out;

    logic                 is64;
    logic                 start;
    logic                 take;
    logic                 load_out;
    logic                 gold_bit;
    t_gold_ctl            gold_ctl;
    t_seq_sts             seq_sts;
    logic [WORD_W-1:0]    packed_word;
    logic [WORD_W-1:0]    seq_in_word;
    logic [WORD_W-1:0]    seq_word;
    logic [23:0]          un_payload;
    logic [3:0]           un_sfn;
    logic [5:0]           un_ssb;
    logic                 un_kmsb;

    assign is64       = (r_mode == MODE_64BLK);
    assign o_in_ready = seq_sts.idle;
    assign start      = i_in_valid && seq_sts.idle;
    // Output register free, or being emptied this cycle
    assign take       = !r_out_valid || i_out_ready;
    assign load_out   = seq_sts.done && take;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_id <= '0;
            r_mode    <= MODE_8BLK;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CELL_ID:    r_cell_id <= i_cfg_data[CELL_ID_W-1:0];
                CFG_BLOCK_MODE: r_mode    <= i_cfg_data[MODE_W-1:0];
                default:        r_mode    <= r_mode;
            endcase
        end
    end

    // Pack: payload element 0 goes to G[14], elements 1..6 to G[0..5],
    // elements 7..23 to G[15..31]; SFN MSB first into G[6..9]; half frame to G[10]
    always_comb begin
        packed_word = '0;
        packed_word[PERM_G[14]] = i_payload_bits[0];
        for (int k = 0; k < 6; k++) begin
            packed_word[PERM_G[k]] = i_payload_bits[k+1];
        end
        for (int k = 15; k < 32; k++) begin
            packed_word[PERM_G[k]] = i_payload_bits[k-8];
        end
        for (int k = 0; k < 4; k++) begin
            packed_word[PERM_G[6+k]] = i_sfn_low[3-k];
        end
        packed_word[PERM_G[10]] = i_half_frame;
        if (is64) begin
            packed_word[PERM_G[11]] = i_block_index[5];
            packed_word[PERM_G[12]] = i_block_index[4];
            packed_word[PERM_G[13]] = i_block_index[3];
        end else begin
            packed_word[PERM_G[11]] = i_offset_msb;
        end
        seq_in_word = (i_kind == KIND_ENC) ? packed_word : i_coded_word;
    end

    // Hold the item context across the sequencer run
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_kind <= i_kind;
            r_ssb  <= i_block_index;
        end
    end

    nrbps_gold u_gold (
        .i_clk  (i_clk),
        .i_ctl  (gold_ctl),
        .i_seed (r_cell_id),
        .o_bit  (gold_bit)
    );

    nrbps_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_word     (seq_in_word),
        .i_is64     (is64),
        .i_take     (take),
        .i_gold_bit (gold_bit),
        .o_gold     (gold_ctl),
        .o_sts      (seq_sts),
        .o_word     (seq_word)
    );

    // Unpack the descrambled word: inverse of the packing above
    always_comb begin
        un_payload    = '0;
        un_payload[0] = seq_word[PERM_G[14]];
        for (int k = 0; k < 6; k++) begin
            un_payload[k+1] = seq_word[PERM_G[k]];
        end
        for (int k = 15; k < 32; k++) begin
            un_payload[k-8] = seq_word[PERM_G[k]];
        end
        for (int k = 0; k < 4; k++) begin
            un_sfn[3-k] = seq_word[PERM_G[6+k]];
        end
        un_ssb  = r_ssb;
        un_kmsb = 1'b0;
        if (is64) begin
            un_ssb[5] = seq_word[PERM_G[11]];
            un_ssb[4] = seq_word[PERM_G[12]];
            un_ssb[3] = seq_word[PERM_G[13]];
        end else begin
            un_kmsb = seq_word[PERM_G[11]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Encode words carry only the scrambled word; decoded fields drop to zero
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_word_out <= seq_word;
            if (r_kind == KIND_DEC) begin
                r_payload_out     <= un_payload;
                r_sfn_out         <= un_sfn;
                r_half_frame_out  <= seq_word[PERM_G[10]];
                r_block_index_out <= un_ssb;
                r_offset_msb_out  <= un_kmsb;
            end else begin
                r_payload_out     <= '0;
                r_sfn_out         <= '0;
                r_half_frame_out  <= 1'b0;
                r_block_index_out <= '0;
                r_offset_msb_out  <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_word_out        = r_word_out;
    assign o_payload_out     = r_payload_out;
    assign o_sfn_out         = r_sfn_out;
    assign o_half_frame_out  = r_half_frame_out;
    assign o_block_index_out = r_block_index_out;
    assign o_offset_msb_out  = r_offset_msb_out;

endmodule

FILE: tb/sv/nr_broadcast_payload_pack_scramble_tb.sv
module nr_broadcast_payload_pack_scramble_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nrbps_pkg::*;

    // The block treats code 3 as a non-64 count; the package has no name for it
    localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;

    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 36;
    // Settle at the end for longer than the slowest word takes
    localparam int SETTLE_CYCLES   = 2000;

    // Idle profiles, indexed by phase modulo 4: none, sender, receiver, both
    localparam int SEND_PCT [4] = '{0, 57, 0, 18};
    localparam int RECV_PCT [4] = '{0, 0, 57, 18};
    // Each profile but 'both' sees a 64-block mode and a non-64 mode; 'both' sees only non-64 modes
    localparam logic [MODE_W-1:0] PHASE_MODES [PHASES] = '{
        MODE_64BLK, MODE_4BLK, MODE_8BLK, MODE_RSVD,
        MODE_8BLK, MODE_64BLK, MODE_64BLK, MODE_4BLK
    };

    // One input word as the sender sees it
    typedef struct packed {
        logic        kind;
        logic [23:0] pl;
        logic [3:0]  sfn;
        logic        hf;
        logic [5:0]  bi;
        logic        ko;
        logic [31:0] coded;
    } msg_t;

    // One output word, field for field
    typedef struct packed {
        logic [31:0] word;
        logic [23:0] pl;
        logic [3:0]  sfn;
        logic        hf;
        logic [5:0]  bi;
        logic        ko;
    } result_t;

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_CELL,
        ROW_MODE
    } row_kind_e;

    // Directed row: a word to send, or a register write (value in cfg).
    // zero_fields pins the unpacked outputs of an encode to zero; the scrambled
    // word itself always comes from the predictor.
    typedef struct packed {
        row_kind_e   what;
        logic        kind;
        logic [23:0] pl;
        logic [3:0]  sfn;
        logic        hf;
        logic [5:0]  bi;
        logic        ko;
        logic [31:0] coded;
        logic [9:0]  cfg;
        logic        zero_fields;
    } dir_row_t;

    localparam int DIR_ROWS_N = 20;
    localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
        // reset values: cell_id 0, 8 blocks
        '{ROW_WORD, KIND_ENC, 24'h000000, 4'h0, 1'b0, 6'd0,  1'b0, 32'h00000000, 10'd0, 1'b1},
        '{ROW_WORD, KIND_ENC, 24'hFFFFFF, 4'hF, 1'b1, 6'd63, 1'b1, 32'h00000000, 10'd0, 1'b1},
        '{ROW_WORD, KIND_DEC, 24'h000000, 4'h0, 1'b0, 6'd0,  1'b0, 32'h00000000, 10'd0, 1'b0},
        '{ROW_WORD, KIND_DEC, 24'hFFFFFF, 4'hF, 1'b1, 6'd63, 1'b1, 32'hFFFFFFFF, 10'd0, 1'b0},
        // both v bits set: longest Gold skip
        '{ROW_WORD, KIND_ENC, 24'h5A5A5A, 4'h6, 1'b0, 6'd21, 1'b0, 32'h00000000, 10'd0, 1'b1},
        // top of the cell id range, 64 blocks
        '{ROW_CELL, KIND_ENC, 24'h000000, 4'h0, 1'b0, 6'd0,  1'b0, 32'h00000000, 10'd1007, 1'b0},
        '{ROW_MODE, KIND_ENC, 24'h000000, 4'h0, 1'b0, 6'd0,  1'b0, 32'h00000000,
          10'(MODE_64BLK), 1'b0},
        '{ROW_WORD, KIND_ENC, 24'hFFFFFF, 4'hF, 1'b1, 6'd63, 1'b1, 32'h00000000, 10'd0, 1'b1},
        '{ROW_WORD, KIND_ENC, 24'hA5A5A5, 4'h2, 1'b0, 6'd40, 1'b1, 32'h00000000, 10'd0, 1'b1},
        '{ROW_WORD, KIND_DEC, 24'h000000, 4'h0, 1'b0, 6'd7,  1'b0, 32'hFFFFFFFF, 10'd0, 1'b0},
        '{ROW_WORD, KIND_DEC, 24'h000000, 4'h0, 1'b0, 6'd56, 1'b1, 32'h12345678, 10'd0, 1'b0},
        // 4 blocks: offset bit takes the reserved slot
        '{ROW_MODE, KIND_ENC, 24'h000000, 4'h0, 1'b0, 6'd0,  1'b0, 32'h00000000,
          10'(MODE_4BLK), 1'b0},
        '{ROW_WORD, KIND_ENC, 24'h000000, 4'h0, 1'b0, 6'd0,  1'b1, 32'h00000000, 10'd0, 1'b1},
        '{ROW_WORD, KIND_DEC, 24'h000000, 4'h0, 1'b0, 6'd45, 1'b0, 32'hDEADBEEF, 10'd0, 1'b0},
        // unnamed mode code 3 behaves as a non-64 count
        '{ROW_MODE, KIND_ENC, 24'h000000, 4'h0, 1'b0, 6'd0,  1'b0, 32'h00000000,
          10'(MODE_RSVD), 1'b0},
        '{ROW_WORD, KIND_ENC, 24'hFFFFFF, 4'hF, 1'b1, 6'd63, 1'b1, 32'h00000000, 10'd0, 1'b1},
        '{ROW_WORD, KIND_DEC, 24'h000000, 4'h0, 1'b0, 6'd42, 1'b0, 32'hFFFFFFFF, 10'd0, 1'b0},
        // cell id above the valid range goes in as a plain 10-bit seed
        '{ROW_CELL, KIND_ENC, 24'h000000, 4'h0, 1'b0, 6'd0,  1'b0, 32'h00000000, 10'd1023, 1'b0},
        '{ROW_WORD, KIND_ENC, 24'h800001, 4'h9, 1'b1, 6'd9,  1'b0, 32'h00000000, 10'd0, 1'b1},
        '{ROW_WORD, KIND_DEC, 24'h000000, 4'h0, 1'b0, 6'd18, 1'b1, 32'h0F0F0F0F, 10'd0, 1'b0}
    };

    logic                  i_clk;
    logic                  i_rst_n           = 1'b0;
    logic                  i_cfg_wr_en       = 1'b0;
    logic                  i_cfg_index       = CFG_CELL_ID;
    logic [CFG_DATA_W-1:0] i_cfg_data        = '0;
    logic                  i_in_valid        = 1'b0;
    logic                  o_in_ready;
    logic                  i_kind            = KIND_ENC;
    logic [23:0]           i_payload_bits    = '0;
    logic [3:0]            i_sfn_low         = '0;
    logic                  i_half_frame      = 1'b0;
    logic [5:0]            i_block_index     = '0;
    logic                  i_offset_msb      = 1'b0;
    logic [31:0]           i_coded_word      = '0;
    logic                  o_out_valid;
    logic                  i_out_ready       = 1'b0;
    logic [31:0]           o_word_out;
    logic [23:0]           o_payload_out;
    logic [3:0]            o_sfn_out;
    logic                  o_half_frame_out;
    logic [5:0]            o_block_index_out;
    logic                  o_offset_msb_out;

    // Mirror of the block's registers, updated as they are written
    logic [CELL_ID_W-1:0]  cell_id_q    = '0;
    logic [MODE_W-1:0]     block_mode_q = MODE_8BLK;

    result_t     pending_words [$];
    logic [31:0] last_scrambled = '0;
    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          stall_left     = 0;

    nr_broadcast_payload_pack_scramble dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_payload_bits    (i_payload_bits),
        .i_sfn_low         (i_sfn_low),
        .i_half_frame      (i_half_frame),
        .i_block_index     (i_block_index),
        .i_offset_msb      (i_offset_msb),
        .i_coded_word      (i_coded_word),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_word_out        (o_word_out),
        .o_payload_out     (o_payload_out),
        .o_sfn_out         (o_sfn_out),
        .o_half_frame_out  (o_half_frame_out),
        .o_block_index_out (o_block_index_out),
        .o_offset_msb_out  (o_offset_msb_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run the two length-31 LFSRs past skip steps, then collect 32 sequence bits
    function automatic logic [31:0] gold_bits(input logic [CELL_ID_W-1:0] seed, input int skip);
        logic [30:0] x1;
        logic [30:0] x2;
        logic [31:0] c;
        logic        f1;
        logic        f2;
        x1 = 31'd1;
        x2 = 31'(seed);
        c  = '0;
        for (int n = 0; n < skip + 32; n++) begin
            f1 = x1[0] ^ x1[3];
            f2 = x2[0] ^ x2[1] ^ x2[2] ^ x2[3];
            if (n >= skip)
                c[n - skip] = x1[0] ^ x2[0];
            x1 = {f1, x1[30:1]};
            x2 = {f2, x2[30:1]};
        end
        return c;
    endfunction

    // Scramble or descramble: the v bits sit in exempt slots, so the same
    // offset comes out of a scrambled word and of a plain one
    function automatic logic [31:0] scramble(input logic [31:0] a, input logic is64);
        logic [31:0] exempt;
        logic [31:0] c;
        logic [31:0] r;
        logic [1:0]  v;
        int          skip;
        int          j;
        exempt = '0;
        exempt[PERM_G[10]] = 1'b1;
        exempt[PERM_G[7]]  = 1'b1;
        exempt[PERM_G[8]]  = 1'b1;
        if (is64) begin
            exempt[PERM_G[11]] = 1'b1;
            exempt[PERM_G[12]] = 1'b1;
            exempt[PERM_G[13]] = 1'b1;
        end
        v    = {a[PERM_G[7]], a[PERM_G[8]]};
        skip = int'(GOLD_NC) + int'(is64 ? STEP_64 : STEP_OTH) * int'(v);
        c    = gold_bits(cell_id_q, skip);
        r    = a;
        j    = 0;
        for (int i = 0; i < 32; i++) begin
            if (!exempt[i]) begin
                r[i] = a[i] ^ c[j];
                j++;
            end
        end
        return r;
    endfunction

    // Slot in G that carries payload bit i: bits 1..6 fill slots 0..5 at
    // the start of G, bit 0 and bits 7..23 fill the rest from slot 14 on
    function automatic int payload_slot(input int i);
        if (i >= 1 && i <= 6)
            return i - 1;
        else if (i == 0)
            return 14;
        else
            return i + 8;
    endfunction

    function automatic result_t pbch_result(input msg_t m);
        result_t     r;
        logic [31:0] w;
        logic        is64;
        is64 = (block_mode_q == MODE_64BLK);
        r    = '0;
        if (m.kind == KIND_ENC) begin
            w = '0;
            for (int i = 0; i < 24; i++)
                w[PERM_G[payload_slot(i)]] = m.pl[i];
            for (int k = 0; k < 4; k++)
                w[PERM_G[6 + k]] = m.sfn[3 - k];
            w[PERM_G[10]] = m.hf;
            if (is64) begin
                w[PERM_G[11]] = m.bi[5];
                w[PERM_G[12]] = m.bi[4];
                w[PERM_G[13]] = m.bi[3];
            end else begin
                w[PERM_G[11]] = m.ko;
            end
            r.word = scramble(w, is64);
        end else begin
            w      = scramble(m.coded, is64);
            r.word = w;
            for (int i = 0; i < 24; i++)
                r.pl[i] = w[PERM_G[payload_slot(i)]];
            for (int k = 0; k < 4; k++)
                r.sfn[3 - k] = w[PERM_G[6 + k]];
            r.hf = w[PERM_G[10]];
            if (is64) begin
                r.bi = {w[PERM_G[11]], w[PERM_G[12]], w[PERM_G[13]], m.bi[2:0]};
                r.ko = 1'b0;
            end else begin
                r.bi = m.bi;
                r.ko = w[PERM_G[11]];
            end
        end
        return r;
    endfunction

    // Random word; a share of decodes take back the last scrambled word,
    // clean or with one bit flipped, so unpacking sees real messages
    function automatic msg_t random_msg();
        msg_t m;
        m.kind  = 1'($urandom_range(0, 1));
        m.pl    = 24'($urandom);
        m.sfn   = 4'($urandom_range(0, 15));
        m.hf    = 1'($urandom_range(0, 1));
        m.bi    = 6'($urandom_range(0, 63));
        m.ko    = 1'($urandom_range(0, 1));
        m.coded = $urandom;
        if (m.kind == KIND_DEC) begin
            case ($urandom_range(0, 3))
                0: m.coded = last_scrambled;
                1: m.coded = last_scrambled ^ (32'd1 << $urandom_range(0, 31));
                default: ;
            endcase
        end
        return m;
    endfunction

    // Present one word and hold it until the block takes it, then queue its result.
    // Called at a clock edge; returns at the edge of acceptance.
    task automatic send_word(input msg_t m, input logic zero_fields);
        int      gap;
        result_t r;
        gap = 0;
        if (send_idle_pct != 0) begin
            // Mostly short gaps, now and then one long enough to land mid-word
            if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(1, 1800);
            else
                while ($urandom_range(0, 99) < send_idle_pct)
                    gap++;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= m.kind;
        i_payload_bits <= m.pl;
        i_sfn_low      <= m.sfn;
        i_half_frame   <= m.hf;
        i_block_index  <= m.bi;
        i_offset_msb   <= m.ko;
        i_coded_word   <= m.coded;
        do @(posedge i_clk); while (!o_in_ready);
        r = pbch_result(m);
        if (zero_fields) begin
            r.pl  = '0;
            r.sfn = '0;
            r.hf  = 1'b0;
            r.bi  = '0;
            r.ko  = 1'b0;
        end
        if (m.kind == KIND_ENC)
            last_scrambled = r.word;
        pending_words.push_back(r);
    endtask

    // Drop valid and wait until every queued word has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
    endtask

    // Single-cycle register write; only called with the block idle
    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_CELL_ID)
            cell_id_q = data[CELL_ID_W-1:0];
        else
            block_mode_q = data[MODE_W-1:0];
    endtask

    // Receiver: random stalls per cycle, plus rare long holds so a finished word
    // waits in the output register while the next one is being worked on
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (recv_stall_pct != 0 && $urandom_range(0, 3999) == 0) begin
            stall_left  <= $urandom_range(100, 2500);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare every taken word with the oldest expectation
    always @(posedge i_clk) begin
        result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                $error("word_out: no word expected, got %h", o_word_out);
                mismatches++;
            end else begin
                want = pending_words.pop_front();
                if (o_word_out !== want.word) begin
                    $error("word_out: expected %h, got %h", want.word, o_word_out);
                    mismatches++;
                end
                if (o_payload_out !== want.pl) begin
                    $error("payload_out: expected %h, got %h", want.pl, o_payload_out);
                    mismatches++;
                end
                if (o_sfn_out !== want.sfn) begin
                    $error("sfn_out: expected %h, got %h", want.sfn, o_sfn_out);
                    mismatches++;
                end
                if (o_half_frame_out !== want.hf) begin
                    $error("half_frame_out: expected %b, got %b", want.hf, o_half_frame_out);
                    mismatches++;
                end
                if (o_block_index_out !== want.bi) begin
                    $error("block_index_out: expected %0d, got %0d", want.bi,
                           o_block_index_out);
                    mismatches++;
                end
                if (o_offset_msb_out !== want.ko) begin
                    $error("offset_msb_out: expected %b, got %b", want.ko, o_offset_msb_out);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        msg_t                  m;
        logic [CFG_DATA_W-1:0] cell_val;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, starting from the reset register values
        for (int r = 0; r < DIR_ROWS_N; r++) begin
            case (DIR_ROWS[r].what)
                ROW_WORD: begin
                    m = '{DIR_ROWS[r].kind, DIR_ROWS[r].pl, DIR_ROWS[r].sfn, DIR_ROWS[r].hf,
                          DIR_ROWS[r].bi, DIR_ROWS[r].ko, DIR_ROWS[r].coded};
                    send_word(m, DIR_ROWS[r].zero_fields);
                end
                ROW_CELL: begin
                    drain();
                    write_reg(CFG_CELL_ID, DIR_ROWS[r].cfg);
                end
                default: begin
                    drain();
                    write_reg(CFG_BLOCK_MODE, DIR_ROWS[r].cfg);
                end
            endcase
        end

        // Random part: each phase sets an idle profile and a fresh configuration
        for (int p = 0; p < PHASES; p++) begin
            drain();
            send_idle_pct  = SEND_PCT[p % 4];
            recv_stall_pct = RECV_PCT[p % 4];
            case (p)
                0: cell_val = 10'd1007;
                2: cell_val = 10'd1023;
                4: cell_val = 10'd0;
                6: cell_val = 10'($urandom_range(1008, 1023));
                default: cell_val = 10'($urandom_range(0, 1007));
            endcase
            write_reg(CFG_CELL_ID, cell_val);
            // Upper data bits are don't-care for the mode register; toggle them
            write_reg(CFG_BLOCK_MODE, {8'($urandom_range(0, 255)), PHASE_MODES[p]});
            repeat (WORDS_PER_PHASE)
                send_word(random_msg(), 1'b0);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: many times the slowest legal run
    initial begin
        #200000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: nr_broadcast_payload_pack_scramble.f
design/nrbps_pkg.sv
design/nrbps_gold.sv
design/nrbps_seq.sv
design/nr_broadcast_payload_pack_scramble.sv
tb/sv/nr_broadcast_payload_pack_scramble_tb.sv
